### design/rbp_pkg.sv
// ----------------------------------------------------------------------------
// rbp_pkg
// Shared sizes, types and codes of the recycling buffer pool.
// ----------------------------------------------------------------------------
package rbp_pkg;

    localparam int POOL_DEPTH  = 16;
    localparam int USE_DEPTH   = 64;
    localparam int SIZE_BITS   = 32;
    localparam int HANDLE_BITS = 48;
    localparam int RATIO_BITS  = 9;
    localparam int THRESH_BITS = 5;
    localparam int RATIO_SHIFT = 8;

    localparam int PCNT_W = $clog2(POOL_DEPTH + 1);
    localparam int UIDX_W = $clog2(USE_DEPTH);
    localparam int CFG_W  = RATIO_BITS;

    localparam logic CFG_RATIO  = 1'b0;
    localparam logic CFG_THRESH = 1'b1;

    localparam logic REQ_ALLOC = 1'b0;

    localparam logic [2:0] ST_REUSED  = 3'd0;
    localparam logic [2:0] ST_FRESH   = 3'd1;
    localparam logic [2:0] ST_POOLED  = 3'd2;
    localparam logic [2:0] ST_UNKNOWN = 3'd3;
    localparam logic [2:0] ST_PFULL   = 3'd4;
    localparam logic [2:0] ST_UFULL   = 3'd5;

    typedef struct packed {
        logic [SIZE_BITS-1:0]   size;
        logic [HANDLE_BITS-1:0] handle;
    } entry_t;

    // Commands from the sequencer to the pool chain.
    typedef struct packed {
        logic   shift;     // every cell takes its neighbor, head leaves
        logic   reinsert;  // the leaving head goes back in at the tail
        logic   push;      // append push_entry at the tail
        entry_t push_entry;
    } pool_ctl_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SLOT,
        S_POOL1,
        S_POOL2,
        S_URD,
        S_UCMP,
        S_FIN
    } state_t;

endpackage

### design/rbp_cell.sv
// ----------------------------------------------------------------------------
// rbp_cell
// One pool cell: holds an entry, loads from its neighbor or the tail input.
// ----------------------------------------------------------------------------
module rbp_cell (
    input  logic            clk,
    input  logic            take_nb,
    input  logic            take_ins,
    input  rbp_pkg::entry_t nb_entry,
    input  rbp_pkg::entry_t ins_entry,
    output rbp_pkg::entry_t entry
);
    import rbp_pkg::*;

    entry_t entry_reg;
    entry_t entry_next;

    // Select the source of the stored entry.
    always_comb
    begin
        entry_next = entry_reg;
        if (take_ins)
        begin
            entry_next = ins_entry;
        end
        else if (take_nb)
        begin
            entry_next = nb_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

### design/rbp_pool.sv
// ----------------------------------------------------------------------------
// rbp_pool
// Ordered free pool as a chain of cells that rotates toward the head.
// ----------------------------------------------------------------------------
module rbp_pool (
    input  logic                      clk,
    input  logic                      rst_n,
    input  rbp_pkg::pool_ctl_t        ctl,
    output rbp_pkg::entry_t           head,
    output logic [rbp_pkg::PCNT_W-1:0] count
);
    import rbp_pkg::*;

    entry_t             cells [POOL_DEPTH];
    entry_t             ins_entry;
    logic [PCNT_W-1:0]  count_reg;
    logic [PCNT_W-1:0]  count_next;

    // The tail input is either the rotating head or a pushed entry.
    assign ins_entry = ctl.push ? ctl.push_entry : cells[0];

    genvar i;
    generate
        for (i = 0; i < POOL_DEPTH; i++)
        begin : g_cell
            logic take_ins;
            logic take_nb;
            entry_t nb;

            assign take_ins = (ctl.shift && ctl.reinsert &&
                               (count_reg == PCNT_W'(i + 1))) ||
                              (ctl.push && (count_reg == PCNT_W'(i)));
            assign take_nb  = ctl.shift && !take_ins;

            if (i == POOL_DEPTH - 1)
            begin : g_last
                assign nb = ins_entry;
            end
            else
            begin : g_mid
                assign nb = cells[i + 1];
            end

            rbp_cell u_cell (
                .clk       (clk),
                .take_nb   (take_nb),
                .take_ins  (take_ins),
                .nb_entry  (nb),
                .ins_entry (ins_entry),
                .entry     (cells[i])
            );
        end
    endgenerate

    // Occupancy follows drops and pushes.
    always_comb
    begin
        count_next = count_reg;
        if (ctl.shift && !ctl.reinsert)
        begin
            count_next = count_reg - PCNT_W'(1);
        end
        else if (ctl.push)
        begin
            count_next = count_reg + PCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    assign head  = cells[0];
    assign count = count_reg;

endmodule

### design/rbp_used.sv
// ----------------------------------------------------------------------------
// rbp_used
// In-use table: size and handle memory with valid flags per slot.
// ----------------------------------------------------------------------------
module rbp_used (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            wr_en,
    input  logic [rbp_pkg::UIDX_W-1:0]      wr_addr,
    input  rbp_pkg::entry_t                 wr_entry,
    input  logic                            clr_en,
    input  logic [rbp_pkg::UIDX_W-1:0]      clr_addr,
    input  logic [rbp_pkg::UIDX_W-1:0]      rd_addr,
    output rbp_pkg::entry_t                 rd_entry,
    output logic                            rd_valid,
    output logic                            addr_valid
);
    import rbp_pkg::*;

    entry_t                mem [USE_DEPTH];
    logic [USE_DEPTH-1:0]  valid_reg;
    logic [USE_DEPTH-1:0]  valid_next;
    entry_t                rd_entry_reg;
    logic                  rd_valid_reg;

    // Memory write and registered read.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_entry;
        end
        rd_entry_reg <= mem[rd_addr];
    end

    // Valid flags, set on allocate, cleared on free.
    always_comb
    begin
        valid_next = valid_reg;
        if (clr_en)
        begin
            valid_next[clr_addr] = 1'b0;
        end
        if (wr_en)
        begin
            valid_next[wr_addr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg    <= valid_next;
            rd_valid_reg <= valid_reg[rd_addr];
        end
    end

    assign rd_entry   = rd_entry_reg;
    assign rd_valid   = rd_valid_reg;
    assign addr_valid = valid_reg[rd_addr];

endmodule

### design/recycling_buffer_pool.sv
// ----------------------------------------------------------------------------
// recycling_buffer_pool
// Sequencer of the pooled block allocator over the cell chain and used table.
// ----------------------------------------------------------------------------
// Allocate scans the used table for a free slot, then, if one is free, rotates
//   the pool through once, and once more when an entry is evicted; free reads
//   and compares one table slot after another. One request is in flight at a time.
// Throughput is set by the table scans, by one pool rotation step a cycle and by out_ready in S_FIN.
// Reset clears the pool count, the used flags and out_valid; no clearing pass.
// ----------------------------------------------------------------------------
module recycling_buffer_pool (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic                               cfg_addr,
    input  logic [rbp_pkg::CFG_W-1:0]          cfg_wdata,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic                               req_type,
    input  logic [rbp_pkg::SIZE_BITS-1:0]      req_size,
    input  logic [rbp_pkg::HANDLE_BITS-1:0]    handle_in,
    input  logic [rbp_pkg::HANDLE_BITS-1:0]    fresh_handle,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [rbp_pkg::HANDLE_BITS-1:0]    out_handle,
    output logic [2:0]                         status,
    output logic                               drop_valid,
    output logic [rbp_pkg::HANDLE_BITS-1:0]    drop_handle
);
    import rbp_pkg::*;

    localparam int PROD_W = SIZE_BITS + RATIO_BITS;
    localparam int CMP_W  = (PCNT_W > THRESH_BITS) ? PCNT_W : THRESH_BITS;

    state_t state_reg, state_next;

    logic [RATIO_BITS-1:0]  ratio_reg;
    logic [THRESH_BITS-1:0] thresh_reg;

    logic                   type_reg;
    logic [SIZE_BITS-1:0]   size_reg;
    logic [HANDLE_BITS-1:0] hin_reg;
    logic [HANDLE_BITS-1:0] fresh_reg;

    logic [UIDX_W-1:0]      idx_reg, idx_next;
    logic [PCNT_W-1:0]      pos_reg, pos_next;
    logic [PCNT_W-1:0]      n_reg, n_next;
    logic                   hit_reg, hit_next;
    logic [SIZE_BITS-1:0]   min_reg, min_next, max_reg, max_next;
    logic [PCNT_W-1:0]      imin_reg, imin_next, imax_reg, imax_next;
    logic [PCNT_W-1:0]      evict_reg, evict_next;

    logic [HANDLE_BITS-1:0] res_oh_reg, res_oh_next;
    logic [2:0]             res_st_reg, res_st_next;
    logic                   res_dv_reg, res_dv_next;
    logic [HANDLE_BITS-1:0] res_dh_reg, res_dh_next;

    logic                   ov_reg;
    logic [HANDLE_BITS-1:0] oh_reg;
    logic [2:0]             st_reg;
    logic                   dv_reg;
    logic [HANDLE_BITS-1:0] dh_reg;

    pool_ctl_t              pctl;
    entry_t                 head;
    logic [PCNT_W-1:0]      pcount;

    logic                   u_wr_en, u_clr_en;
    entry_t                 u_wr_entry;
    entry_t                 u_rd_entry;
    logic                   u_rd_valid, u_addr_valid;

    logic [PROD_W-1:0]      prod;
    logic                   fits;
    logic                   last_slot;
    logic                   evict;

    rbp_pool u_pool (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (pctl),
        .head  (head),
        .count (pcount)
    );

    rbp_used u_used (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr_en      (u_wr_en),
        .wr_addr    (idx_reg),
        .wr_entry   (u_wr_entry),
        .clr_en     (u_clr_en),
        .clr_addr   (idx_reg),
        .rd_addr    (idx_reg),
        .rd_entry   (u_rd_entry),
        .rd_valid   (u_rd_valid),
        .addr_valid (u_addr_valid)
    );

    // Fit test on the pool head: large enough and not too wasteful.
    assign prod = PROD_W'(head.size) * PROD_W'(ratio_reg);
    assign fits = (head.size >= size_reg) &&
                  ((prod >> RATIO_SHIFT) <= PROD_W'(size_reg));

    assign last_slot = (idx_reg == UIDX_W'(USE_DEPTH - 1));

    // Eviction decision once the first pass has missed.
    assign evict = (n_reg != '0) &&
                   (CMP_W'(n_reg) >= CMP_W'(thresh_reg)) &&
                   ((max_reg < size_reg) || (min_reg > size_reg));

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = (req_type == REQ_ALLOC) ? S_SLOT : S_URD;
                end
            end
            S_SLOT:
            begin
                if (!u_addr_valid)
                begin
                    state_next = S_POOL1;
                end
                else if (last_slot)
                begin
                    state_next = S_FIN;
                end
            end
            S_POOL1:
            begin
                if (pos_reg == n_reg)
                begin
                    state_next = (!hit_reg && evict) ? S_POOL2 : S_FIN;
                end
            end
            S_POOL2:
            begin
                if (pos_reg == n_reg)
                begin
                    state_next = S_FIN;
                end
            end
            S_URD:
            begin
                state_next = S_UCMP;
            end
            S_UCMP:
            begin
                if ((u_rd_valid && u_rd_entry.handle == hin_reg) || last_slot)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    state_next = S_URD;
                end
            end
            S_FIN:
            begin
                if (!ov_reg || out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Datapath and command outputs of each state.
    always_comb
    begin
        idx_next    = idx_reg;
        pos_next    = pos_reg;
        n_next      = n_reg;
        hit_next    = hit_reg;
        min_next    = min_reg;
        max_next    = max_reg;
        imin_next   = imin_reg;
        imax_next   = imax_reg;
        evict_next  = evict_reg;
        res_oh_next = res_oh_reg;
        res_st_next = res_st_reg;
        res_dv_next = res_dv_reg;
        res_dh_next = res_dh_reg;
        pctl        = '0;
        u_wr_en     = 1'b0;
        u_clr_en    = 1'b0;
        u_wr_entry  = '{size: size_reg, handle: fresh_reg};
        case (state_reg)
            S_IDLE:
            begin
                idx_next    = '0;
                pos_next    = '0;
                hit_next    = 1'b0;
                res_dv_next = 1'b0;
                res_dh_next = '0;
            end
            S_SLOT:
            begin
                if (!u_addr_valid)
                begin
                    n_next = pcount;
                end
                else if (last_slot)
                begin
                    res_oh_next = fresh_reg;
                    res_st_next = ST_UFULL;
                end
                else
                begin
                    idx_next = idx_reg + UIDX_W'(1);
                end
            end
            S_POOL1:
            begin
                if (pos_reg != n_reg)
                begin
                    pos_next   = pos_reg + PCNT_W'(1);
                    pctl.shift = 1'b1;
                    if (!hit_reg && fits)
                    begin
                        // First fitting entry leaves the pool for the table.
                        hit_next      = 1'b1;
                        res_oh_next   = head.handle;
                        res_st_next   = ST_REUSED;
                        u_wr_en       = 1'b1;
                        u_wr_entry    = head;
                        pctl.reinsert = 1'b0;
                    end
                    else
                    begin
                        pctl.reinsert = 1'b1;
                        if (!hit_reg)
                        begin
                            if (pos_reg == '0 || head.size < min_reg)
                            begin
                                min_next  = head.size;
                                imin_next = pos_reg;
                            end
                            if (pos_reg == '0 || head.size > max_reg)
                            begin
                                max_next  = head.size;
                                imax_next = pos_reg;
                            end
                        end
                    end
                end
                else if (!hit_reg)
                begin
                    res_oh_next = fresh_reg;
                    res_st_next = ST_FRESH;
                    pos_next    = '0;
                    evict_next  = (max_reg < size_reg) ? imin_reg : imax_reg;
                    if (!evict)
                    begin
                        u_wr_en = 1'b1;
                    end
                end
            end
            S_POOL2:
            begin
                if (pos_reg != n_reg)
                begin
                    pos_next      = pos_reg + PCNT_W'(1);
                    pctl.shift    = 1'b1;
                    pctl.reinsert = (pos_reg != evict_reg);
                    if (pos_reg == evict_reg)
                    begin
                        res_dv_next = 1'b1;
                        res_dh_next = head.handle;
                    end
                end
                else
                begin
                    u_wr_en = 1'b1;
                end
            end
            S_URD:
            begin
                res_oh_next = hin_reg;
            end
            S_UCMP:
            begin
                if (u_rd_valid && u_rd_entry.handle == hin_reg)
                begin
                    u_clr_en = 1'b1;
                    if (pcount >= PCNT_W'(POOL_DEPTH))
                    begin
                        res_st_next = ST_PFULL;
                    end
                    else
                    begin
                        res_st_next     = ST_POOLED;
                        pctl.push       = 1'b1;
                        pctl.push_entry = '{size: u_rd_entry.size, handle: hin_reg};
                    end
                end
                else if (last_slot)
                begin
                    res_st_next = ST_UNKNOWN;
                end
                else
                begin
                    idx_next = idx_reg + UIDX_W'(1);
                end
            end
            S_FIN:
            begin
            end
            default:
            begin
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            ratio_reg  <= '0;
            thresh_reg <= THRESH_BITS'(10);
            ov_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                case (cfg_addr)
                    CFG_RATIO:  ratio_reg  <= cfg_wdata;
                    CFG_THRESH: thresh_reg <= cfg_wdata[THRESH_BITS-1:0];
                    default:    ;
                endcase
            end
            if (state_reg == S_FIN && (!ov_reg || out_ready))
            begin
                ov_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                ov_reg <= 1'b0;
            end
        end
    end

    // Request, scan and result registers.
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_valid)
        begin
            type_reg  <= req_type;
            size_reg  <= req_size;
            hin_reg   <= handle_in;
            fresh_reg <= fresh_handle;
        end
        idx_reg    <= idx_next;
        pos_reg    <= pos_next;
        n_reg      <= n_next;
        hit_reg    <= hit_next;
        min_reg    <= min_next;
        max_reg    <= max_next;
        imin_reg   <= imin_next;
        imax_reg   <= imax_next;
        evict_reg  <= evict_next;
        res_oh_reg <= res_oh_next;
        res_st_reg <= res_st_next;
        res_dv_reg <= res_dv_next;
        res_dh_reg <= res_dh_next;
        if (state_reg == S_FIN && (!ov_reg || out_ready))
        begin
            oh_reg <= res_oh_reg;
            st_reg <= res_st_reg;
            dv_reg <= res_dv_reg & (type_reg == REQ_ALLOC);
            dh_reg <= res_dh_reg;
        end
    end

    assign in_ready    = (state_reg == S_IDLE);
    assign out_valid   = ov_reg;
    assign out_handle  = oh_reg;
    assign status      = st_reg;
    assign drop_valid  = dv_reg;
    assign drop_handle = dh_reg;

endmodule

### sim/tb_recycling_buffer_pool.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_recycling_buffer_pool
// Drives allocate and free requests into the buffer pool and checks every
// result against a behavioral pool and in-use table kept in the bench.
// ----------------------------------------------------------------------------
module tb_recycling_buffer_pool;

    import rbp_pkg::*;

    typedef struct {
        logic                   kind;
        logic [SIZE_BITS-1:0]   size;
        logic [HANDLE_BITS-1:0] hin;
        logic [HANDLE_BITS-1:0] fresh;
    } request_t;

    typedef struct {
        logic [HANDLE_BITS-1:0] handle;
        logic [2:0]             st;
        logic                   dv;
        logic [HANDLE_BITS-1:0] dh;
    } answer_t;

    // Directed rows: known answers are given where they are obvious.
    typedef struct {
        request_t req;
        logic     known;
        answer_t  ans;
    } row_t;

    localparam logic REQ_FREE = 1'b1;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic                   cfg_addr;
    logic [CFG_W-1:0]       cfg_wdata;
    logic                   in_valid;
    logic                   in_ready;
    logic                   req_type;
    logic [SIZE_BITS-1:0]   req_size;
    logic [HANDLE_BITS-1:0] handle_in;
    logic [HANDLE_BITS-1:0] fresh_handle;
    logic                   out_valid;
    logic                   out_ready;
    logic [HANDLE_BITS-1:0] out_handle;
    logic [2:0]             status;
    logic                   drop_valid;
    logic [HANDLE_BITS-1:0] drop_handle;

    // Bench copy of the block state.
    logic [8:0]             ratio_q;
    logic [4:0]             thresh_q;
    logic [SIZE_BITS-1:0]   pool_sz [POOL_DEPTH];
    logic [HANDLE_BITS-1:0] pool_hd [POOL_DEPTH];
    int                     pool_n;
    logic [SIZE_BITS-1:0]   used_sz [USE_DEPTH];
    logic [HANDLE_BITS-1:0] used_hd [USE_DEPTH];
    logic                   used_on [USE_DEPTH];

    answer_t                pending_answers[$];
    logic [HANDLE_BITS-1:0] live_handles[$];
    int                     errors;
    int                     sent;
    int                     received;
    int                     reused_cnt;
    int                     drop_cnt;
    logic                   stall_on;

    recycling_buffer_pool i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .req_type    (req_type),
        .req_size    (req_size),
        .handle_in   (handle_in),
        .fresh_handle(fresh_handle),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_handle  (out_handle),
        .status      (status),
        .drop_valid  (drop_valid),
        .drop_handle (drop_handle)
    );

    // Clock generation.
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Watchdog.
    initial
    begin
        #20ms;
        $display("tb_recycling_buffer_pool failed");
        $finish;
    end

    // True when (size * ratio) >> 8 does not exceed the request.
    function automatic logic fill_ok(logic [SIZE_BITS-1:0] sz, logic [8:0] r,
                                     logic [SIZE_BITS-1:0] want);
        logic [SIZE_BITS+8:0] prod;
        begin
            prod = {9'd0, sz} * r;
            return (prod >> RATIO_SHIFT) <= want;
        end
    endfunction

    function automatic void pool_drop_at(int idx);
        for (int i = idx; i + 1 < pool_n; i++)
        begin
            pool_sz[i] = pool_sz[i + 1];
            pool_hd[i] = pool_hd[i + 1];
        end
        pool_n--;
    endfunction

    // Computes the answer of one request and updates the bench state.
    function automatic answer_t allocator_step(request_t rq);
        answer_t a;
        int      slot;
        int      found;
        int      imin;
        int      imax;
        logic    hit;
        begin
            a = '{handle: '0, st: ST_REUSED, dv: 1'b0, dh: '0};
            if (rq.kind == REQ_ALLOC)
            begin
                slot = -1;
                for (int i = 0; i < USE_DEPTH; i++)
                    if (slot < 0 && !used_on[i]) slot = i;
                if (slot < 0)
                begin
                    a.handle = rq.fresh;
                    a.st = ST_UFULL;
                end
                else
                begin
                    hit = 1'b0;
                    imin = 0;
                    imax = 0;
                    for (int i = 0; i < pool_n && !hit; i++)
                    begin
                        if (pool_sz[i] >= rq.size && fill_ok(pool_sz[i], ratio_q, rq.size))
                        begin
                            a.handle = pool_hd[i];
                            used_sz[slot] = pool_sz[i];
                            used_hd[slot] = pool_hd[i];
                            used_on[slot] = 1'b1;
                            pool_drop_at(i);
                            a.st = ST_REUSED;
                            hit = 1'b1;
                        end
                        else
                        begin
                            if (pool_sz[i] < pool_sz[imin]) imin = i;
                            if (pool_sz[i] > pool_sz[imax]) imax = i;
                        end
                    end
                    if (!hit)
                    begin
                        if (pool_n > 0 && pool_n >= thresh_q)
                        begin
                            if (pool_sz[imax] < rq.size)
                            begin
                                a.dv = 1'b1;
                                a.dh = pool_hd[imin];
                                pool_drop_at(imin);
                            end
                            else if (pool_sz[imin] > rq.size)
                            begin
                                a.dv = 1'b1;
                                a.dh = pool_hd[imax];
                                pool_drop_at(imax);
                            end
                        end
                        used_sz[slot] = rq.size;
                        used_hd[slot] = rq.fresh;
                        used_on[slot] = 1'b1;
                        a.handle = rq.fresh;
                        a.st = ST_FRESH;
                    end
                end
            end
            else
            begin
                found = -1;
                for (int k = 0; k < USE_DEPTH; k++)
                    if (found < 0 && used_on[k] && used_hd[k] == rq.hin) found = k;
                a.handle = rq.hin;
                if (found < 0)
                    a.st = ST_UNKNOWN;
                else
                begin
                    used_on[found] = 1'b0;
                    if (pool_n >= POOL_DEPTH)
                        a.st = ST_PFULL;
                    else
                    begin
                        pool_sz[pool_n] = used_sz[found];
                        pool_hd[pool_n] = rq.hin;
                        pool_n++;
                        a.st = ST_POOLED;
                    end
                end
            end
            return a;
        end
    endfunction

    // Receiver stall pattern and result checking.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            stall_on  <= 1'b0;
        end
        else
        begin
            if ($urandom_range(0, 99) < 3) stall_on <= ~stall_on;
            out_ready <= stall_on ? ($urandom_range(0, 3) == 0) : 1'b1;
            if (out_valid && out_ready)
            begin
                received <= received + 1;
                if (pending_answers.size() == 0)
                begin
                    errors = errors + 1;
                    if (errors <= 10) $display("unexpected result handle %h", out_handle);
                end
                else
                begin
                    answer_t e;
                    e = pending_answers.pop_front();
                    if (out_handle !== e.handle || status !== e.st
                        || drop_valid !== e.dv || drop_handle !== e.dh)
                    begin
                        errors = errors + 1;
                        if (errors <= 10)
                            $display("mismatch: exp h=%h st=%0d dv=%b dh=%h got h=%h st=%0d dv=%b dh=%h",
                                     e.handle, e.st, e.dv, e.dh,
                                     out_handle, status, drop_valid, drop_handle);
                    end
                    if (e.st == ST_REUSED) reused_cnt++;
                    if (e.dv) drop_cnt++;
                end
            end
        end
    end

    // Sends one request; checks a typed answer against the predictor too.
    task automatic send_request(request_t rq, logic known, answer_t ans);
        answer_t a;
        begin
            in_valid     <= 1'b1;
            req_type     <= rq.kind;
            req_size     <= rq.size;
            handle_in    <= rq.hin;
            fresh_handle <= rq.fresh;
            @(posedge clk);
            while (!in_ready) @(posedge clk);
            a = allocator_step(rq);
            if (known && (a.handle !== ans.handle || a.st !== ans.st
                          || a.dv !== ans.dv || a.dh !== ans.dh))
            begin
                errors++;
                if (errors <= 10)
                    $display("row mismatch: exp h=%h st=%0d dv=%b dh=%h got h=%h st=%0d dv=%b dh=%h",
                             ans.handle, ans.st, ans.dv, ans.dh,
                             a.handle, a.st, a.dv, a.dh);
            end
            pending_answers.insert(pending_answers.size(), a);
            if (rq.kind == REQ_ALLOC && a.st != ST_UFULL)
                live_handles.insert(live_handles.size(), a.handle);
            sent++;
        end
    endtask

    // Idle gap between bursts; valid drops only here and while draining results.
    task automatic sender_gap(int cycles);
        begin
            if (cycles > 0)
            begin
                in_valid <= 1'b0;
                repeat (cycles) @(posedge clk);
            end
        end
    endtask

    task automatic drain_results();
        begin
            in_valid <= 1'b0;
            while (pending_answers.size() != 0) @(posedge clk);
            repeat (200) @(posedge clk);
        end
    endtask

    // One register write; the write enable is dropped again before the task returns.
    task automatic write_register(logic idx, logic [CFG_W-1:0] val);
        begin
            cfg_we    <= 1'b1;
            cfg_addr  <= idx;
            cfg_wdata <= val;
            @(posedge clk);
            cfg_we    <= 1'b0;
            if (idx == CFG_RATIO) ratio_q = val;
            else thresh_q = val[4:0];
            @(posedge clk);
        end
    endtask

    function automatic logic [SIZE_BITS-1:0] pick_size();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return $urandom_range(0, 3);
            2: return 32'hFFFF_FFFF - $urandom_range(0, 3);
            default: return $urandom_range(0, 1023);
        endcase
    endfunction

    function automatic logic [HANDLE_BITS-1:0] pick_handle();
        return HANDLE_BITS'({$urandom(), $urandom()});
    endfunction

    // Random phase: allocs and frees alike, most frees of live handles, mostly small sizes.
    task automatic random_phase(int count);
        request_t rq;
        int       burst;
        int       idx;
        begin
            burst = 0;
            for (int n = 0; n < count; n++)
            begin
                if (burst == 0)
                begin
                    sender_gap($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12));
                    burst = $urandom_range(1, 20);
                end
                burst--;
                rq.size  = pick_size();
                rq.fresh = pick_handle();
                rq.hin   = pick_handle();
                rq.kind  = ($urandom_range(0, 1) == 0) ? REQ_ALLOC : REQ_FREE;
                if (rq.kind == REQ_FREE && live_handles.size() > 0
                    && $urandom_range(0, 9) < 8)
                begin
                    idx = $urandom_range(0, live_handles.size() - 1);
                    rq.hin = live_handles[idx];
                    live_handles.delete(idx);
                end
                send_request(rq, 1'b0, '{default: '0});
            end
        end
    endtask

    row_t rows[$];

    initial
    begin
        request_t rq;
        errors = 0;
        sent = 0;
        received = 0;
        reused_cnt = 0;
        drop_cnt = 0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_addr = CFG_RATIO;
        cfg_wdata = '0;
        in_valid = 1'b0;
        req_type = REQ_ALLOC;
        req_size = '0;
        handle_in = '0;
        fresh_handle = '0;
        ratio_q = 9'd0;
        thresh_q = 5'd10;
        pool_n = 0;
        for (int i = 0; i < USE_DEPTH; i++) used_on[i] = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table: fresh allocs, frees, unknown handle, reuse, extremes.
        rows.insert(rows.size(), '{'{REQ_FREE, 32'd0, 48'h1234, 48'd0}, 1'b1,
                                   '{48'h1234, ST_UNKNOWN, 1'b0, 48'd0}});
        rows.insert(rows.size(), '{'{REQ_ALLOC, 32'd100, 48'd0, 48'hA1}, 1'b1,
                                   '{48'hA1, ST_FRESH, 1'b0, 48'd0}});
        rows.insert(rows.size(), '{'{REQ_ALLOC, 32'hFFFF_FFFF, 48'd0, 48'hFFFF_FFFF_FFFF},
                                   1'b1, '{48'hFFFF_FFFF_FFFF, ST_FRESH, 1'b0, 48'd0}});
        rows.insert(rows.size(), '{'{REQ_ALLOC, 32'd0, 48'd0, 48'd0}, 1'b1,
                                   '{48'd0, ST_FRESH, 1'b0, 48'd0}});
        rows.insert(rows.size(), '{'{REQ_FREE, 32'd0, 48'hA1, 48'd0}, 1'b1,
                                   '{48'hA1, ST_POOLED, 1'b0, 48'd0}});
        rows.insert(rows.size(), '{'{REQ_FREE, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 48'd0},
                                   1'b1, '{48'hFFFF_FFFF_FFFF, ST_POOLED, 1'b0, 48'd0}});
        rows.insert(rows.size(), '{'{REQ_FREE, 32'd0, 48'd0, 48'd0}, 1'b1,
                                   '{48'd0, ST_POOLED, 1'b0, 48'd0}});
        rows.insert(rows.size(), '{'{REQ_ALLOC, 32'd50, 48'd0, 48'hB2}, 1'b0,
                                   '{default: '0}});
        rows.insert(rows.size(), '{'{REQ_ALLOC, 32'd1, 48'd0, 48'hB3}, 1'b0,
                                   '{default: '0}});
        rows.insert(rows.size(), '{'{REQ_FREE, 32'd7, 48'hB2, 48'd5}, 1'b0,
                                   '{default: '0}});
        foreach (rows[i]) send_request(rows[i].req, rows[i].known, rows[i].ans);
        drain_results();

        // Threshold zero, so a miss may evict whenever the pool is nonempty; ratio at 256.
        write_register(CFG_THRESH, 9'd0);
        write_register(CFG_RATIO, 9'd256);
        for (int i = 0; i < 6; i++)
        begin
            rq = '{REQ_FREE, 32'd0, live_handles.size() ? live_handles.pop_front() : 48'd9,
                   48'd0};
            send_request(rq, 1'b0, '{default: '0});
        end
        random_phase(150);
        drain_results();

        // Ratio over 256 and a mid threshold.
        write_register(CFG_RATIO, 9'h1FF);
        write_register(CFG_THRESH, 9'd4);
        random_phase(150);
        drain_results();

        // Fill the in-use table to reach the full case, then free heavily.
        write_register(CFG_THRESH, 9'd16);
        write_register(CFG_RATIO, 9'd192);
        for (int i = 0; i < USE_DEPTH + 4; i++)
        begin
            rq = '{REQ_ALLOC, 32'($urandom_range(0, 4095)), pick_handle(), pick_handle()};
            send_request(rq, 1'b0, '{default: '0});
        end
        while (live_handles.size() > 0)
        begin
            rq = '{REQ_FREE, 32'd0, live_handles.pop_front(), 48'd0};
            send_request(rq, 1'b0, '{default: '0});
        end
        drain_results();

        write_register(CFG_THRESH, 9'd31);
        write_register(CFG_RATIO, 9'd128);
        random_phase(200);
        drain_results();

        $display("Sent %0d requests, %0d results: %0d reuses, %0d evictions.",
                 sent, received, reused_cnt, drop_cnt);
        $display("Ratio and threshold swept through zero, mid values and extremes.");
        if (errors == 0 && pending_answers.size() == 0)
            $display("tb_recycling_buffer_pool passed");
        else
            $display("tb_recycling_buffer_pool failed");
        $finish;
    end

endmodule

### sim.f
design/rbp_pkg.sv
design/rbp_cell.sv
design/rbp_pool.sv
design/rbp_used.sv
design/recycling_buffer_pool.sv
sim/tb_recycling_buffer_pool.sv
